@@ rtl/gaps_pkg.sv @@
package gaps_pkg;

   // grid geometry, fixed by the 6-bit coordinate fields
   localparam int COORD_W    = 6;
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int CELL_W     = 2 * COORD_W;
   localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
   localparam int DIM_W      = 7;
   localparam int LEN_W      = 12;
   localparam int TRACE_W    = LEN_W + 1;

   // costs, unsigned fixed point
   localparam int FRAC_BITS     = 8;
   localparam int COST_W        = 24;
   localparam int KEY_W         = 24;
   localparam int STRAIGHT_COST = 1 << FRAC_BITS;
   // floor(sqrt(2) * 2^FRAC_BITS)
   localparam int DIAG_COST     = 362;
   localparam int DIR_W         = 3;

   // heuristic square root operand: (dx*dx + dy*dy) << (2*FRAC_BITS), rounded to even width
   localparam int HEUR_SUM_W  = 2 * COORD_W + 1;
   localparam int SQRT_ROOT_W = (HEUR_SUM_W + 2 * FRAC_BITS + 1) / 2;
   localparam int SQRT_IN_W   = 2 * SQRT_ROOT_W;

   // open list entry {key, x, y}: one unsigned compare gives key, then x, then y order
   localparam int ENTRY_W    = KEY_W + 2 * COORD_W;
   localparam int HEAP_DEPTH = 8192;

   // stream word widths
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;

   // opcodes
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOPATH   = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_RANGE    = 2'd3;

   // configuration register indexes
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   typedef logic signed [1:0] offset_type;

   // neighbor column offset per direction
   function automatic offset_type dir_dx(input logic [DIR_W-1:0] d);
      offset_type r;
      case (d)
         3'd0, 3'd1:       r = 2'sd0;
         3'd2, 3'd3, 3'd4: r = -2'sd1;
         default:          r = 2'sd1;
      endcase
      return r;
   endfunction

   // neighbor row offset per direction
   function automatic offset_type dir_dy(input logic [DIR_W-1:0] d);
      offset_type r;
      case (d)
         3'd0, 3'd3, 3'd6: r = -2'sd1;
         3'd2, 3'd5:       r = 2'sd0;
         default:          r = 2'sd1;
      endcase
      return r;
   endfunction

   // register value 0 acts as 1, above the maximum acts as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > lim) r = lim;
      else r = v;
      return r;
   endfunction

endpackage

@@ rtl/gaps_isqrt.sv @@
module gaps_isqrt #(
   parameter int ROOT_W = gaps_pkg::SQRT_ROOT_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2*ROOT_W-1:0] operand,
   output logic                done,
   output logic [ROOT_W-1:0]   root
);
   import gaps_pkg::*;

   localparam int IN_W  = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [IN_W-1:0]   src_ff, src_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W+1:0]  rem_shift;
   logic [REM_W+1:0]  trial;

   // one result bit per cycle, two operand bits brought down each step
   assign rem_shift = {rem_ff, src_ff[IN_W-1 -: 2]};
   assign trial     = (REM_W + 2)'({root_ff, 2'b01});

   always_comb begin
      src_in  = src_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         src_in  = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         src_in = {src_ff[IN_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = REM_W'(rem_shift - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_shift);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      src_ff  <= src_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

`ifndef NO_ASSERTIONS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(busy_ff))
      else $error("root ready without a running extraction");
   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff)
      else $error("root ready while still iterating");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff < CNT_W'(ROOT_W))
      else $error("iteration count past root width");
`endif

endmodule

@@ rtl/grid_astar_path_search_unit.sv @@
// Grid path search unit: A* over an 8-connected obstacle grid of up to 64 x 64 cells.
// Request words (req_*) carry an opcode in req_tuser: write one obstacle cell, run a
// search from start to goal, or read one cell of the last found path. Every request
// gives exactly one response word (rsp_*) with status, path length and the read cell.
// csr_* writes grid width (index 0) and grid height (index 1); write only while idle.
// An obstacle write is answered from the response state; a path read first passes S_PATHRD.
// A search first clears its visit marks, then per expanded cell pops the open list with
// a sift-down, and per accepted neighbor reads its memory state, waits for the square
// root and sifts the new entry up the open list; the open-list memory, with one read
// and one write port, and the bit-serial root set the search time. Path tracing walks
// the path twice, once to count its cells and once to store them. One request is worked on at a time.
// After reset the obstacle map is swept clear with req_tready low.
// The response sits in an output register; a new request is taken while it waits,
// and a finished result waits for rsp_tready before it is loaded.
module grid_astar_path_search_unit #(
   parameter int HEAP_DEPTH = gaps_pkg::HEAP_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: cell_x, cell_y, blocked, start_x, start_y, goal_x, goal_y, path_index
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gaps_pkg::REQ_DATA_W-1:0]     req_tdata,
   // request: opcode
   input  logic [1:0]                          req_tuser,
   // response: status, path_length, step_x, step_y
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gaps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic                                csr_addr,
   input  logic [gaps_pkg::DIM_W-1:0]          csr_wdata
);
   import gaps_pkg::*;

   localparam int IDX_W = $clog2(HEAP_DEPTH);
   localparam int CNT_W = IDX_W + 1;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_CLR    = 5'd1;
   localparam logic [4:0] S_INIT   = 5'd2;
   localparam logic [4:0] S_PATHRD = 5'd3;
   localparam logic [4:0] S_RSP    = 5'd4;
   localparam logic [4:0] S_POP    = 5'd5;
   localparam logic [4:0] S_POP1   = 5'd6;
   localparam logic [4:0] S_POP2   = 5'd7;
   localparam logic [4:0] S_SD0    = 5'd8;
   localparam logic [4:0] S_SD1    = 5'd9;
   localparam logic [4:0] S_SD2    = 5'd10;
   localparam logic [4:0] S_SD3    = 5'd11;
   localparam logic [4:0] S_SDW    = 5'd12;
   localparam logic [4:0] S_CUR    = 5'd13;
   localparam logic [4:0] S_NB     = 5'd14;
   localparam logic [4:0] S_NB1    = 5'd15;
   localparam logic [4:0] S_SQ     = 5'd16;
   localparam logic [4:0] S_PU0    = 5'd17;
   localparam logic [4:0] S_PU1    = 5'd18;
   localparam logic [4:0] S_TR0    = 5'd19;
   localparam logic [4:0] S_TR1    = 5'd20;
   localparam logic [4:0] S_TR2    = 5'd21;
   localparam logic [4:0] S_TR3    = 5'd22;

   localparam logic [DIM_W-1:0] LIM_W = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] LIM_H = DIM_W'(MAX_HEIGHT);

   // request fields
   logic [COORD_W-1:0] f_cell_x, f_cell_y, f_start_x, f_start_y, f_goal_x, f_goal_y;
   logic               f_blocked;
   logic [LEN_W-1:0]   f_path_index;

   assign f_cell_x     = req_tdata[5:0];
   assign f_cell_y     = req_tdata[11:6];
   assign f_blocked    = req_tdata[12];
   assign f_start_x    = req_tdata[18:13];
   assign f_start_y    = req_tdata[24:19];
   assign f_goal_x     = req_tdata[30:25];
   assign f_goal_y     = req_tdata[36:31];
   assign f_path_index = req_tdata[48:37];

   // control and datapath registers
   logic [4:0]         state_ff, state_in;
   logic               clr_obst_ff, clr_obst_in;
   logic [CELL_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [DIM_W-1:0]   grid_w_ff, grid_h_ff;
   logic [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in, gx_ff, gx_in, gy_ff, gy_in;
   logic [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COST_W-1:0]  cur_cost_ff, cur_cost_in;
   logic [DIR_W-1:0]   dir_ff, dir_in;
   logic [COORD_W-1:0] nbr_x_ff, nbr_x_in, nbr_y_ff, nbr_y_in;
   logic [COST_W-1:0]  nc_ff, nc_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   hi_ff, hi_in, cidx_ff, cidx_in;
   logic [ENTRY_W-1:0] top_ff, top_in, last_ff, last_in, child_ff, child_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [TRACE_W-1:0] n_ff, n_in, k_ff, k_in;
   logic [LEN_W-1:0]   stored_len_ff, stored_len_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [COORD_W-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memories and their ports
   logic               obst_mem [CELLS];
   logic [1:0]         mark_mem [CELLS];  // {discovered, closed}
   logic [COST_W-1:0]  cost_mem [CELLS];
   logic [DIR_W-1:0]   dir_mem  [CELLS];
   logic [ENTRY_W-1:0] heap_mem [HEAP_DEPTH];
   logic [CELL_W-1:0]  path_mem [CELLS];

   logic               obst_we, obst_wdata, mark_we, cost_we, dir_we, heap_we, path_we;
   logic [CELL_W-1:0]  obst_waddr, cell_waddr, cell_raddr, dir_raddr;
   logic [1:0]         mark_wdata;
   logic [COST_W-1:0]  cost_wdata;
   logic [DIR_W-1:0]   dir_wdata;
   logic [IDX_W-1:0]   heap_waddr, heap_raddr;
   logic [ENTRY_W-1:0] heap_wdata;
   logic [LEN_W-1:0]   path_waddr, path_raddr;
   logic [CELL_W-1:0]  path_wdata;
   logic               obst_rd_ff;
   logic [1:0]         mark_rd_ff;
   logic [COST_W-1:0]  cost_rd_ff;
   logic [DIR_W-1:0]   dir_rd_ff;
   logic [ENTRY_W-1:0] heap_rd_ff;
   logic [CELL_W-1:0]  path_rd_ff;

   // square root unit for the heuristic
   logic                   sq_start, sq_done;
   logic [SQRT_IN_W-1:0]   sq_operand;
   logic [SQRT_ROOT_W-1:0] sq_root;

   gaps_isqrt #(.ROOT_W(SQRT_ROOT_W)) u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_operand),
      .done    (sq_done),
      .root    (sq_root)
   );

   // derived values
   logic [DIM_W-1:0]   eff_w, eff_h;
   logic               req_fire;
   offset_type         ddx, ddy, tdx, tdy;
   logic signed [7:0]  nx_s, ny_s;
   logic               nb_inside;
   logic [COST_W-1:0]  nc_calc;
   logic [COORD_W-1:0] hx, hy;
   logic [HEUR_SUM_W-1:0] hsum;
   logic [IDX_W:0]     sd_c;
   logic [IDX_W+1:0]   sd_c1;

   assign eff_w    = clamp_dim(grid_w_ff, LIM_W);
   assign eff_h    = clamp_dim(grid_h_ff, LIM_H);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;

   // neighbor position for the current direction
   assign ddx       = dir_dx(dir_ff);
   assign ddy       = dir_dy(dir_ff);
   assign nx_s      = $signed({2'b00, cur_x_ff}) + 8'(ddx);
   assign ny_s      = $signed({2'b00, cur_y_ff}) + 8'(ddy);
   assign nb_inside = !nx_s[7] && !ny_s[7] && (nx_s[6:0] < eff_w) && (ny_s[6:0] < eff_h);
   assign nc_calc   = cur_cost_ff + ((ddx != 2'sd0 && ddy != 2'sd0)
                      ? COST_W'(DIAG_COST) : COST_W'(STRAIGHT_COST));

   // heuristic operand from the registered neighbor
   assign hx         = (nbr_x_ff > gx_ff) ? nbr_x_ff - gx_ff : gx_ff - nbr_x_ff;
   assign hy         = (nbr_y_ff > gy_ff) ? nbr_y_ff - gy_ff : gy_ff - nbr_y_ff;
   assign hsum       = HEUR_SUM_W'(hx * hx) + HEUR_SUM_W'(hy * hy);
   assign sq_operand = SQRT_IN_W'({hsum, {(2 * FRAC_BITS){1'b0}}});

   // heap child indexes for the sift-down
   assign sd_c  = {hi_ff, 1'b1};
   assign sd_c1 = {1'b0, sd_c} + 1'b1;

   // back-step offsets from the stored direction
   assign tdx = dir_dx(dir_rd_ff);
   assign tdy = dir_dy(dir_rd_ff);

   always_comb begin
      state_in      = state_ff;
      clr_obst_in   = clr_obst_ff;
      clr_addr_in   = clr_addr_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      gx_in         = gx_ff;
      gy_in         = gy_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      cur_cost_in   = cur_cost_ff;
      dir_in        = dir_ff;
      nbr_x_in      = nbr_x_ff;
      nbr_y_in      = nbr_y_ff;
      nc_in         = nc_ff;
      count_in      = count_ff;
      hi_in         = hi_ff;
      cidx_in       = cidx_ff;
      top_in        = top_ff;
      last_in       = last_ff;
      child_in      = child_ff;
      entry_in      = entry_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      stored_len_in = stored_len_ff;
      res_status_in = res_status_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      obst_we    = 1'b0;
      obst_waddr = {f_cell_y, f_cell_x};
      obst_wdata = f_blocked;
      mark_we    = 1'b0;
      cost_we    = 1'b0;
      dir_we     = 1'b0;
      cell_waddr = {nbr_y_ff, nbr_x_ff};
      mark_wdata = 2'b10;
      cost_wdata = nc_calc;
      dir_wdata  = dir_ff;
      cell_raddr = {ny_s[5:0], nx_s[5:0]};
      dir_raddr  = {py_ff, px_ff};
      heap_we    = 1'b0;
      heap_waddr = hi_ff;
      heap_wdata = entry_ff;
      heap_raddr = '0;
      path_we    = 1'b0;
      path_waddr = LEN_W'(k_ff - 1'b1);
      path_wdata = {py_ff, px_ff};
      path_raddr = f_path_index;
      sq_start   = 1'b0;

      case (state_ff)
         // take a request word
         S_IDLE: begin
            if (req_fire) begin
               res_status_in = ST_OK;
               res_x_in      = '0;
               res_y_in      = '0;
               state_in      = S_RSP;
               case (req_tuser)
                  OP_WRITE: begin
                     obst_we = 1'b1;
                  end
                  OP_SEARCH: begin
                     stored_len_in = '0;
                     sx_in = f_start_x;
                     sy_in = f_start_y;
                     gx_in = f_goal_x;
                     gy_in = f_goal_y;
                     if (DIM_W'(f_start_x) >= eff_w || DIM_W'(f_start_y) >= eff_h ||
                         DIM_W'(f_goal_x) >= eff_w || DIM_W'(f_goal_y) >= eff_h) begin
                        res_status_in = ST_NOPATH;
                     end else begin
                        clr_addr_in = '0;
                        state_in    = S_CLR;
                     end
                  end
                  OP_READ: begin
                     if (f_path_index < stored_len_ff) state_in = S_PATHRD;
                     else res_status_in = ST_RANGE;
                  end
                  default: ;
               endcase
            end
         end
         // sweep marks, and after reset the obstacle map too
         S_CLR: begin
            mark_we     = 1'b1;
            mark_wdata  = 2'b00;
            cell_waddr  = clr_addr_ff;
            obst_we     = clr_obst_ff;
            obst_waddr  = clr_addr_ff;
            obst_wdata  = 1'b0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CELL_W'(CELLS - 1)) begin
               clr_obst_in = 1'b0;
               state_in    = clr_obst_ff ? S_IDLE : S_INIT;
            end
         end
         // seed the open list with the start cell
         S_INIT: begin
            cell_waddr = {sy_ff, sx_ff};
            mark_we    = 1'b1;
            mark_wdata = 2'b10;
            cost_we    = 1'b1;
            cost_wdata = '0;
            heap_we    = 1'b1;
            heap_waddr = '0;
            heap_wdata = {KEY_W'(0), sx_ff, sy_ff};
            count_in   = CNT_W'(1);
            state_in   = S_POP;
         end
         S_PATHRD: begin
            res_x_in = path_rd_ff[COORD_W-1:0];
            res_y_in = path_rd_ff[CELL_W-1:COORD_W];
            state_in = S_RSP;
         end
         // load the output register when it is free
         S_RSP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({res_y_ff, res_x_ff, stored_len_ff, res_status_ff});
               state_in     = S_IDLE;
            end
         end
         // pop: report no path on an empty list, else read top, then last
         S_POP: begin
            if (count_ff == '0) begin
               res_status_in = ST_NOPATH;
               state_in      = S_RSP;
            end else begin
               heap_raddr = '0;
               state_in   = S_POP1;
            end
         end
         S_POP1: begin
            top_in     = heap_rd_ff;
            heap_raddr = IDX_W'(count_ff - 1'b1);
            count_in   = count_ff - 1'b1;
            state_in   = S_POP2;
         end
         S_POP2: begin
            last_in  = heap_rd_ff;
            hi_in    = '0;
            state_in = S_SD0;
         end
         // sift-down: left child
         S_SD0: begin
            if (sd_c >= count_ff) begin
               state_in = S_SDW;
            end else begin
               heap_raddr = sd_c[IDX_W-1:0];
               state_in   = S_SD1;
            end
         end
         // right child when present
         S_SD1: begin
            child_in = heap_rd_ff;
            cidx_in  = sd_c[IDX_W-1:0];
            if (sd_c1 < {1'b0, count_ff}) begin
               heap_raddr = sd_c1[IDX_W-1:0];
               state_in   = S_SD2;
            end else begin
               state_in = S_SD3;
            end
         end
         S_SD2: begin
            if (heap_rd_ff < child_ff) begin
               child_in = heap_rd_ff;
               cidx_in  = sd_c1[IDX_W-1:0];
            end
            state_in = S_SD3;
         end
         S_SD3: begin
            if (child_ff < last_ff) begin
               heap_we    = 1'b1;
               heap_waddr = hi_ff;
               heap_wdata = child_ff;
               hi_in      = cidx_ff;
               state_in   = S_SD0;
            end else begin
               state_in = S_SDW;
            end
         end
         // place the last entry, fetch the popped cell's marks and cost
         S_SDW: begin
            if (count_ff != '0) begin
               heap_we    = 1'b1;
               heap_waddr = hi_ff;
               heap_wdata = last_ff;
            end
            cell_raddr = {top_ff[COORD_W-1:0], top_ff[CELL_W-1:COORD_W]};
            cur_x_in   = top_ff[CELL_W-1:COORD_W];
            cur_y_in   = top_ff[COORD_W-1:0];
            state_in   = S_CUR;
         end
         // close the cell or skip it
         S_CUR: begin
            if (mark_rd_ff[0]) begin
               state_in = S_POP;
            end else begin
               mark_we     = 1'b1;
               mark_wdata  = 2'b11;
               cell_waddr  = {cur_y_ff, cur_x_ff};
               cur_cost_in = cost_rd_ff;
               if (cur_x_ff == gx_ff && cur_y_ff == gy_ff) begin
                  px_in    = gx_ff;
                  py_in    = gy_ff;
                  n_in     = '0;
                  state_in = S_TR0;
               end else begin
                  dir_in   = '0;
                  state_in = S_NB;
               end
            end
         end
         // neighbor: bounds check, then read its state
         S_NB: begin
            nbr_x_in = nx_s[5:0];
            nbr_y_in = ny_s[5:0];
            if (nb_inside) begin
               state_in = S_NB1;
            end else if (dir_ff == 3'd7) begin
               state_in = S_POP;
            end else begin
               dir_in = dir_ff + 1'b1;
            end
         end
         // relax the neighbor
         S_NB1: begin
            if (obst_rd_ff || mark_rd_ff[0] || (mark_rd_ff[1] && nc_calc >= cost_rd_ff)) begin
               if (dir_ff == 3'd7) state_in = S_POP;
               else begin
                  dir_in   = dir_ff + 1'b1;
                  state_in = S_NB;
               end
            end else begin
               mark_we = 1'b1;
               cost_we = 1'b1;
               dir_we  = 1'b1;
               nc_in   = nc_calc;
               if (count_ff >= CNT_W'(HEAP_DEPTH)) begin
                  res_status_in = ST_OVERFLOW;
                  state_in      = S_RSP;
               end else begin
                  sq_start = 1'b1;
                  state_in = S_SQ;
               end
            end
         end
         S_SQ: begin
            if (sq_done) begin
               entry_in = {nc_ff + COST_W'(sq_root), nbr_x_ff, nbr_y_ff};
               hi_in    = count_ff[IDX_W-1:0];
               count_in = count_ff + 1'b1;
               state_in = S_PU0;
            end
         end
         // push: sift up toward the root
         S_PU0: begin
            if (hi_ff == '0) begin
               heap_we    = 1'b1;
               heap_waddr = '0;
               heap_wdata = entry_ff;
               if (dir_ff == 3'd7) state_in = S_POP;
               else begin
                  dir_in   = dir_ff + 1'b1;
                  state_in = S_NB;
               end
            end else begin
               heap_raddr = IDX_W'((hi_ff - 1'b1) >> 1);
               state_in   = S_PU1;
            end
         end
         S_PU1: begin
            heap_we = 1'b1;
            if (entry_ff < heap_rd_ff) begin
               heap_wdata = heap_rd_ff;
               hi_in      = IDX_W'((hi_ff - 1'b1) >> 1);
               state_in   = S_PU0;
            end else begin
               heap_wdata = entry_ff;
               if (dir_ff == 3'd7) state_in = S_POP;
               else begin
                  dir_in   = dir_ff + 1'b1;
                  state_in = S_NB;
               end
            end
         end
         // trace: count steps from goal back to start
         S_TR0: begin
            if ((px_ff == sx_ff && py_ff == sy_ff) || n_ff[TRACE_W-1]) begin
               px_in    = gx_ff;
               py_in    = gy_ff;
               k_in     = n_ff;
               state_in = S_TR2;
            end else begin
               state_in = S_TR1;
            end
         end
         S_TR1: begin
            px_in    = px_ff - COORD_W'(tdx);
            py_in    = py_ff - COORD_W'(tdy);
            n_in     = n_ff + 1'b1;
            state_in = S_TR0;
         end
         // trace again, storing cells from the last step down
         S_TR2: begin
            if (k_ff == '0) begin
               stored_len_in = n_ff[LEN_W-1:0];
               res_status_in = ST_OK;
               state_in      = S_RSP;
            end else begin
               path_we  = 1'b1;
               state_in = S_TR3;
            end
         end
         S_TR3: begin
            px_in    = px_ff - COORD_W'(tdx);
            py_in    = py_ff - COORD_W'(tdy);
            k_in     = k_ff - 1'b1;
            state_in = S_TR2;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_obst_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         count_ff      <= '0;
         stored_len_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         grid_w_ff     <= DIM_W'(60);
         grid_h_ff     <= DIM_W'(50);
      end else begin
         state_ff      <= state_in;
         clr_obst_ff   <= clr_obst_in;
         clr_addr_ff   <= clr_addr_in;
         count_ff      <= count_in;
         stored_len_ff <= stored_len_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we && csr_addr == CSR_GRID_WIDTH) grid_w_ff <= csr_wdata;
         if (csr_we && csr_addr == CSR_GRID_HEIGHT) grid_h_ff <= csr_wdata;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      gx_ff         <= gx_in;
      gy_ff         <= gy_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      cur_cost_ff   <= cur_cost_in;
      dir_ff        <= dir_in;
      nbr_x_ff      <= nbr_x_in;
      nbr_y_ff      <= nbr_y_in;
      nc_ff         <= nc_in;
      hi_ff         <= hi_in;
      cidx_ff       <= cidx_in;
      top_ff        <= top_in;
      last_ff       <= last_in;
      child_ff      <= child_in;
      entry_ff      <= entry_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      n_ff          <= n_in;
      k_ff          <= k_in;
      res_status_ff <= res_status_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // cell memories
   always_ff @(posedge clock) begin
      if (obst_we) obst_mem[obst_waddr] <= obst_wdata;
      if (mark_we) mark_mem[cell_waddr] <= mark_wdata;
      if (cost_we) cost_mem[cell_waddr] <= cost_wdata;
      if (dir_we) dir_mem[cell_waddr] <= dir_wdata;
      obst_rd_ff <= obst_mem[cell_raddr];
      mark_rd_ff <= mark_mem[cell_raddr];
      cost_rd_ff <= cost_mem[cell_raddr];
      dir_rd_ff  <= dir_mem[dir_raddr];
   end

   // open list memory
   always_ff @(posedge clock) begin
      if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
      heap_rd_ff <= heap_mem[heap_raddr];
   end

   // path memory
   always_ff @(posedge clock) begin
      if (path_we) path_mem[path_waddr] <= path_wdata;
      path_rd_ff <= path_mem[path_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HEAP_DEPTH))
      else $error("open list count beyond depth");
   a_push_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PU0 || state_ff == S_PU1) |-> {1'b0, hi_ff} < count_ff)
      else $error("sift-up index outside the open list");
   a_root_when_waiting: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> state_ff == S_SQ)
      else $error("heuristic root arrived outside its wait state");
   a_failed_search_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RSP && (res_status_ff == ST_NOPATH || res_status_ff == ST_OVERFLOW))
      |-> stored_len_ff == '0)
      else $error("failed search left a stored path");
`endif

endmodule

@@ bench/testbench.sv @@
module testbench;
   import gaps_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 5000000;

   typedef struct {
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
      logic        blocked;
      logic [5:0]  start_x;
      logic [5:0]  start_y;
      logic [5:0]  goal_x;
      logic [5:0]  goal_y;
      logic [11:0] path_index;
   } request_t;

   typedef struct {
      logic [1:0]  status;
      logic [11:0] path_length;
      logic [5:0]  step_x;
      logic [5:0]  step_y;
   } answer_t;

   typedef struct {
      longint key;
      int     x;
      int     y;
   } open_entry_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic csr_addr = 1'b0;
   logic [DIM_W-1:0] csr_wdata = '0;

   // predictor copy of the block state
   int          grid_w_reg = 60;
   int          grid_h_reg = 50;
   bit          wall_map [0:CELLS-1];
   longint      cost_tab [0:CELLS-1];
   bit          seen_tab [0:CELLS-1];
   bit          closed_tab [0:CELLS-1];
   int          from_dir [0:CELLS-1];
   open_entry_t frontier [0:HEAP_DEPTH-1];
   int          frontier_n;
   int          route_cells [0:CELLS-1];
   int          route_len = 0;
   int          step_dx [0:7] = '{0, 0, -1, -1, -1, 1, 1, 1};
   int          step_dy [0:7] = '{-1, 1, 0, -1, 1, 0, -1, 1};

   answer_t pending_answers [$];
   int      send_idle_pct = 0;
   int      rsp_idle_pct = 0;
   bit      failed = 1'b0;
   int      cycle_count = 0;

   grid_astar_path_search_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[grid_astar_path_search_unit] ERROR");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // compare each response word with the oldest expectation
   always @(posedge clock) begin
      answer_t want;
      answer_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = rsp_tdata[1:0];
         got.path_length = rsp_tdata[13:2];
         got.step_x      = rsp_tdata[19:14];
         got.step_y      = rsp_tdata[25:20];
         if (pending_answers.size() == 0) begin
            $display("%0t unexpected word: expected none, actual %h", $time, rsp_tdata);
            failed = 1'b1;
         end else begin
            want = pending_answers.pop_front();
            if (got.status != want.status) begin
               $display("%0t status: expected %0d, actual %0d", $time, want.status,
                        got.status);
               failed = 1'b1;
            end
            if (got.path_length != want.path_length) begin
               $display("%0t path_length: expected %0d, actual %0d", $time,
                        want.path_length, got.path_length);
               failed = 1'b1;
            end
            if (got.step_x != want.step_x) begin
               $display("%0t step_x: expected %0d, actual %0d", $time, want.step_x,
                        got.step_x);
               failed = 1'b1;
            end
            if (got.step_y != want.step_y) begin
               $display("%0t step_y: expected %0d, actual %0d", $time, want.step_y,
                        got.step_y);
               failed = 1'b1;
            end
         end
      end
   end

   function automatic longint isqrt(longint v);
      longint r;
      longint b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bit entry_first(open_entry_t a, open_entry_t b);
      if (a.key != b.key) return a.key < b.key;
      if (a.x != b.x) return a.x < b.x;
      return a.y < b.y;
   endfunction

   function automatic void frontier_push(open_entry_t e);
      int i;
      int p;
      i = frontier_n;
      frontier_n++;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!entry_first(e, frontier[p])) break;
         frontier[i] = frontier[p];
         i = p;
      end
      frontier[i] = e;
   endfunction

   function automatic open_entry_t frontier_pop();
      open_entry_t top;
      open_entry_t last;
      int i;
      int c;
      top = frontier[0];
      frontier_n--;
      last = frontier[frontier_n];
      i = 0;
      forever begin
         c = 2 * i + 1;
         if (c >= frontier_n) break;
         if (c + 1 < frontier_n && entry_first(frontier[c + 1], frontier[c])) c++;
         if (!entry_first(frontier[c], last)) break;
         frontier[i] = frontier[c];
         i = c;
      end
      if (frontier_n > 0) frontier[i] = last;
      return top;
   endfunction

   function automatic int eff_dim(int v, int lim);
      if (v < 1) return 1;
      return (v > lim) ? lim : v;
   endfunction

   // A* from start to goal, fills the stored route
   function automatic logic [1:0] find_route(int sx, int sy, int gx, int gy);
      int w;
      int h;
      int s;
      int g;
      int p;
      int n;
      int k;
      int c;
      int nx;
      int ny;
      int ni;
      longint nc;
      longint hx;
      longint hy;
      bit found;
      open_entry_t e;
      open_entry_t cur;
      w = eff_dim(grid_w_reg, MAX_WIDTH);
      h = eff_dim(grid_h_reg, MAX_HEIGHT);
      found = 1'b0;
      route_len = 0;
      if (sx >= w || sy >= h || gx >= w || gy >= h) return ST_NOPATH;
      for (int i = 0; i < CELLS; i++) begin
         seen_tab[i] = 1'b0;
         closed_tab[i] = 1'b0;
      end
      frontier_n = 0;
      s = sy * MAX_WIDTH + sx;
      g = gy * MAX_WIDTH + gx;
      cost_tab[s] = 0;
      seen_tab[s] = 1'b1;
      e.key = 0; e.x = sx; e.y = sy;
      frontier_push(e);
      while (frontier_n > 0 && !found) begin
         cur = frontier_pop();
         c = cur.y * MAX_WIDTH + cur.x;
         if (!closed_tab[c]) begin
            closed_tab[c] = 1'b1;
            if (c == g) begin
               found = 1'b1;
            end else begin
               for (int d = 0; d < 8; d++) begin
                  nx = cur.x + step_dx[d];
                  ny = cur.y + step_dy[d];
                  if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                  ni = ny * MAX_WIDTH + nx;
                  if (wall_map[ni] || closed_tab[ni]) continue;
                  nc = cost_tab[c] + ((step_dx[d] != 0 && step_dy[d] != 0) ?
                                      DIAG_COST : STRAIGHT_COST);
                  if (seen_tab[ni] && nc >= cost_tab[ni]) continue;
                  cost_tab[ni] = nc;
                  seen_tab[ni] = 1'b1;
                  from_dir[ni] = d;
                  if (frontier_n >= HEAP_DEPTH) return ST_OVERFLOW;
                  hx = (nx > gx) ? nx - gx : gx - nx;
                  hy = (ny > gy) ? ny - gy : gy - ny;
                  e.key = nc + isqrt((hx * hx + hy * hy) << (2 * FRAC_BITS));
                  e.x = nx; e.y = ny;
                  frontier_push(e);
               end
            end
         end
      end
      if (!found) return ST_NOPATH;
      // walk back to the start, then fill from the goal end
      n = 0;
      p = g;
      while (p != s && n < CELLS) begin
         p = p - step_dy[from_dir[p]] * MAX_WIDTH - step_dx[from_dir[p]];
         n++;
      end
      p = g;
      for (k = n; k > 0; k--) begin
         route_cells[k - 1] = p;
         p = p - step_dy[from_dir[p]] * MAX_WIDTH - step_dx[from_dir[p]];
      end
      route_len = n;
      return ST_OK;
   endfunction

   function automatic answer_t predict_answer(logic [1:0] op, request_t r);
      answer_t a;
      a.status = ST_OK;
      a.step_x = '0;
      a.step_y = '0;
      case (op)
         OP_WRITE: begin
            wall_map[r.cell_y * MAX_WIDTH + r.cell_x] = r.blocked;
         end
         OP_SEARCH: begin
            a.status = find_route(r.start_x, r.start_y, r.goal_x, r.goal_y);
         end
         OP_READ: begin
            if (r.path_index < route_len) begin
               a.step_x = COORD_W'(route_cells[r.path_index] % MAX_WIDTH);
               a.step_y = COORD_W'(route_cells[r.path_index] / MAX_WIDTH);
            end else begin
               a.status = ST_RANGE;
            end
         end
         default: ;
      endcase
      a.path_length = LEN_W'(route_len);
      return a;
   endfunction

   // send one request word and queue its expected answer
   task automatic send_req(logic [1:0] op, request_t r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, r.path_index, r.goal_y, r.goal_x, r.start_y, r.start_x,
                     r.blocked, r.cell_y, r.cell_x};
      do @(posedge clock); while (!req_tready);
      pending_answers = {pending_answers, predict_answer(op, r)};
   endtask

   task automatic write_cell(int x, int y, bit b);
      request_t r;
      r = '{default: '0};
      r.cell_x = COORD_W'(x); r.cell_y = COORD_W'(y); r.blocked = b;
      send_req(OP_WRITE, r);
   endtask

   task automatic search(int sx, int sy, int gx, int gy);
      request_t r;
      r = '{default: '0};
      r.start_x = COORD_W'(sx); r.start_y = COORD_W'(sy);
      r.goal_x = COORD_W'(gx); r.goal_y = COORD_W'(gy);
      send_req(OP_SEARCH, r);
   endtask

   task automatic read_step(int idx);
      request_t r;
      r = '{default: '0};
      r.path_index = LEN_W'(idx);
      send_req(OP_READ, r);
   endtask

   // stop sending and wait until every answer is in
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_grid(int w, int h);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_GRID_WIDTH;
      csr_wdata <= DIM_W'(w);
      @(posedge clock);
      csr_addr  <= CSR_GRID_HEIGHT;
      csr_wdata <= DIM_W'(h);
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      grid_w_reg = w;
      grid_h_reg = h;
   endtask

   // default 60 x 50 grid right after reset
   task automatic test_reset_grid();
      read_step(0);
      search(5, 5, 5, 5);
      search(0, 0, 60, 0);
      search(0, 0, 59, 49);
      read_step(0);
      read_step(58);
      read_step(59);
      read_step(4095);
   endtask

   // writes, blocked endpoints and the unused opcode on a small grid
   task automatic test_special_cells();
      request_t r;
      set_grid(4, 4);
      write_cell(63, 63, 1'b1);
      write_cell(3, 3, 1'b1);
      search(0, 0, 3, 3);
      search(3, 3, 3, 3);
      write_cell(0, 0, 1'b1);
      search(0, 0, 2, 0);
      read_step(1);
      write_cell(0, 0, 1'b0);
      write_cell(3, 3, 1'b0);
      r.cell_x = 6'h3f; r.cell_y = 6'h3f; r.blocked = 1'b1;
      r.start_x = 6'h3f; r.start_y = 6'h3f; r.goal_x = 6'h3f; r.goal_y = 6'h3f;
      r.path_index = 12'hfff;
      send_req(OP_UNUSED, r);
      search(0, 3, 3, 0);
      read_step(0);
   endtask

   // register extremes: zero, above maximum, the maximum itself
   task automatic test_grid_extremes();
      set_grid(0, 127);
      search(0, 0, 0, 63);
      read_step(62);
      write_cell(0, 5, 1'b1);
      search(0, 0, 0, 63);
      write_cell(0, 5, 1'b0);
      set_grid(127, 64);
      search(0, 0, 62, 63);
      read_step(61);
      write_cell(63, 63, 1'b0);
      set_grid(64, 1);
      search(63, 0, 0, 0);
      read_step(0);
   endtask

   // random traffic on small grids
   task automatic test_random(int count);
      request_t r;
      logic [1:0] op;
      int w;
      int h;
      int pick;
      set_grid($urandom_range(9, 2), $urandom_range(9, 2));
      w = eff_dim(grid_w_reg, MAX_WIDTH);
      h = eff_dim(grid_h_reg, MAX_HEIGHT);
      for (int i = 0; i < count; i++) begin
         r.cell_x = COORD_W'($urandom); r.cell_y = COORD_W'($urandom);
         r.blocked = 1'($urandom);
         r.start_x = COORD_W'($urandom); r.start_y = COORD_W'($urandom);
         r.goal_x = COORD_W'($urandom); r.goal_y = COORD_W'($urandom);
         r.path_index = LEN_W'($urandom);
         pick = $urandom_range(99);
         if (pick < 40) begin
            op = OP_WRITE;
            if ($urandom_range(9) != 0) begin
               r.cell_x = COORD_W'($urandom_range(w - 1));
               r.cell_y = COORD_W'($urandom_range(h - 1));
            end
            r.blocked = ($urandom_range(99) < 30);
         end else if (pick < 55) begin
            op = OP_SEARCH;
            if ($urandom_range(9) != 0) begin
               r.start_x = COORD_W'($urandom_range(w - 1));
               r.start_y = COORD_W'($urandom_range(h - 1));
               r.goal_x  = COORD_W'($urandom_range(w - 1));
               r.goal_y  = COORD_W'($urandom_range(h - 1));
            end
         end else if (pick < 95) begin
            op = OP_READ;
            if ($urandom_range(9) != 0) r.path_index = LEN_W'($urandom_range(route_len + 1));
         end else begin
            op = OP_UNUSED;
         end
         send_req(op, r);
      end
   endtask

   initial begin
      for (int i = 0; i < CELLS; i++) wall_map[i] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 16;
      rsp_idle_pct = 58;
      test_reset_grid();
      test_special_cells();
      test_grid_extremes();
      test_random(22);
      send_idle_pct = 58;
      rsp_idle_pct = 16;
      test_random(22);
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random(22);
      drain();
      if (!failed) begin
         $display("[grid_astar_path_search_unit] OK");
      end else begin
         $display("[grid_astar_path_search_unit] ERROR");
      end
      $finish;
   end

endmodule
